// ----- rtl/core/jsl_pkg.sv -----
`default_nettype none
package jsl_pkg;

  typedef enum logic [4:0] {
    S_START, S_EFIRST, S_ESEP, S_ENEXT, S_NFIRST, S_NSEP, S_VSTART, S_MSEP,
    S_MNEXT, S_STR, S_ESC, S_HEX, S_LOW, S_ISTART, S_ICONT, S_IEND, S_FSTART,
    S_FCONT, S_XSTART, S_XISTART, S_XICONT, S_FALSE, S_NULL, S_TRUE
  } lex_state_e;

  // Where a cached frame below the top comes from in the current cycle.
  typedef enum logic [1:0] {
    SRC_REG, SRC_RDA, SRC_RDB
  } frame_src_e;

  localparam logic [4:0] ST_OK      = 5'd0;
  localparam logic [4:0] ST_FAIL    = 5'd1;
  localparam logic [4:0] ST_NODATA  = 5'd2;
  localparam logic [4:0] ST_OVER    = 5'd3;
  localparam logic [4:0] ST_UNDER   = 5'd4;
  localparam logic [4:0] ST_VALUE   = 5'd5;
  localparam logic [4:0] ST_COMMA   = 5'd6;
  localparam logic [4:0] ST_QUOTE   = 5'd7;
  localparam logic [4:0] ST_COLON   = 5'd8;
  localparam logic [4:0] ST_PRINT   = 5'd9;
  localparam logic [4:0] ST_ESC     = 5'd10;
  localparam logic [4:0] ST_HEX     = 5'd11;
  localparam logic [4:0] ST_HI      = 5'd12;
  localparam logic [4:0] ST_LO      = 5'd13;
  localparam logic [4:0] ST_UTF8    = 5'd14;
  localparam logic [4:0] ST_DIGIT   = 5'd15;
  localparam logic [4:0] ST_DECIMAL = 5'd16;
  localparam logic [4:0] ST_LITERAL = 5'd17;
  localparam logic [4:0] ST_AGAIN   = 5'd31;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_BYTES = 3'd1;
  localparam logic [2:0] EV_START = 3'd2;
  localparam logic [2:0] EV_END   = 3'd3;
  localparam logic [2:0] EV_DEND  = 3'd4;

  localparam logic [2:0] K_STR = 3'd1;
  localparam logic [2:0] K_NUM = 3'd2;
  localparam logic [2:0] K_ARR = 3'd3;
  localparam logic [2:0] K_OBJ = 3'd4;
  localparam logic [2:0] K_LIT = 3'd5;

  localparam logic [4:0] F_BYTES = 5'd1;
  localparam logic [4:0] F_FIRST = 5'd2;
  localparam logic [4:0] F_ELEM  = 5'd4;
  localparam logic [4:0] F_NAME  = 5'd8;
  localparam logic [4:0] F_VAL   = 5'd16;

  localparam logic [1:0] LIT_FALSE = 2'd0;
  localparam logic [1:0] LIT_NULL  = 2'd1;
  localparam logic [1:0] LIT_TRUE  = 2'd2;

  typedef struct packed {
    logic [4:0] status;
    logic [2:0] etype;
    logic [2:0] kind;
    logic [4:0] flags;
    logic [2:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } event_t;

  // Result of one lexing pass: the event plus the state changes it asks for.
  typedef struct packed {
    event_t     ev;
    logic       wr;
    lex_state_e wr_state;
    logic       push;
    lex_state_e push_state;
    logic       pop;
    logic       cnt_wr;
    logic [3:0] cnt;
    logic       val_wr;
    logic [31:0] val;
  } step_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd9) || (c == 8'd10) || (c == 8'd13) || (c == 8'd32);
  endfunction

  function automatic logic is_num_end(logic [7:0] c);
    return is_ws(c) || (c == ",") || (c == "]") || (c == "}");
  endfunction

  // Letters map to 10..15 since their low nibble is 1..6.
  function automatic logic [3:0] nibble(logic [7:0] c);
    return is_dig(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [3:0] bump(logic [3:0] n);
    return (n == 4'd15) ? 4'd15 : n + 4'd1;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] which, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (which)
      LIT_FALSE: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      LIT_NULL: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic event_t ev_none(logic [4:0] st);
    event_t e;
    e = '0;
    e.status = st;
    return e;
  endfunction

  function automatic event_t ev_byte(logic [7:0] c);
    event_t e;
    e = ev_none(ST_OK);
    e.etype = EV_BYTES;
    e.flags = F_BYTES;
    e.count = 3'd1;
    e.b0 = c;
    return e;
  endfunction

  // Code point to UTF-8.
  function automatic event_t ev_code(logic [31:0] cp);
    event_t e;
    e = ev_byte(8'd0);
    if (cp < 32'h80) begin
      e.b0 = cp[7:0];
    end else if (cp < 32'h800) begin
      e.count = 3'd2;
      e.b0 = {3'b110, cp[10:6]};
      e.b1 = {2'b10, cp[5:0]};
    end else if (cp < 32'h10000) begin
      e.count = 3'd3;
      e.b0 = {4'b1110, cp[15:12]};
      e.b1 = {2'b10, cp[11:6]};
      e.b2 = {2'b10, cp[5:0]};
    end else if (cp < 32'h110000) begin
      e.count = 3'd4;
      e.b0 = {5'b11110, cp[20:18]};
      e.b1 = {2'b10, cp[17:12]};
      e.b2 = {2'b10, cp[11:6]};
      e.b3 = {2'b10, cp[5:0]};
    end else begin
      e = ev_none(ST_UTF8);
    end
    return e;
  endfunction

  function automatic step_t st_push(step_t r, logic [2:0] kind, logic [4:0] flags,
                                    lex_state_e s, logic [7:0] first, logic ok);
    logic has;
    has = (first != 8'd0);
    if (!ok) begin
      r.ev = ev_none(ST_OVER);
    end else begin
      r.push = 1'b1;
      r.push_state = s;
      r.cnt_wr = 1'b1;
      r.cnt = has ? 4'd1 : 4'd0;
      r.ev = ev_none(ST_OK);
      r.ev.etype = EV_START;
      r.ev.kind = kind;
      r.ev.flags = flags | (has ? F_BYTES : 5'd0);
      r.ev.count = has ? 3'd1 : 3'd0;
      r.ev.b0 = first;
    end
    return r;
  endfunction

  function automatic step_t st_pop(step_t r, logic [2:0] kind, logic [4:0] st,
                                   logic [7:0] last, logic top_nz);
    r.ev = ev_none(ST_UNDER);
    r.ev.etype = EV_END;
    r.ev.kind = kind;
    if (last != 8'd0) begin
      r.ev.flags = F_BYTES;
      r.ev.count = 3'd1;
      r.ev.b0 = last;
    end
    if (top_nz) begin
      r.pop = 1'b1;
      r.ev.status = st;
    end
    r.cnt_wr = 1'b1;
    r.cnt = 4'd0;
    return r;
  endfunction

  function automatic step_t st_to(step_t r, lex_state_e s);
    r.wr = 1'b1;
    r.wr_state = s;
    r.ev = ev_none(ST_OK);
    return r;
  endfunction

  function automatic step_t st_byte_to(step_t r, lex_state_e s, logic [7:0] c);
    r.wr = 1'b1;
    r.wr_state = s;
    r.ev = ev_byte(c);
    return r;
  endfunction

  function automatic step_t value_then(step_t r, lex_state_e s);
    if (r.ev.status == ST_OK) begin
      r.wr = 1'b1;
      r.wr_state = s;
    end
    return r;
  endfunction

  function automatic step_t take_value(step_t r, logic [4:0] flags, logic [7:0] c,
                                       logic ok);
    case (c)
      "\"":    r = st_push(r, K_STR, flags, S_STR, 8'd0, ok);
      "-":     r = st_push(r, K_NUM, flags, S_ISTART, c, ok);
      "0":     r = st_push(r, K_NUM, flags, S_IEND, c, ok);
      "[":     r = st_push(r, K_ARR, flags, S_EFIRST, 8'd0, ok);
      "{":     r = st_push(r, K_OBJ, flags, S_NFIRST, 8'd0, ok);
      "f":     r = st_push(r, K_LIT, flags, S_FALSE, c, ok);
      "n":     r = st_push(r, K_LIT, flags, S_NULL, c, ok);
      "t":     r = st_push(r, K_LIT, flags, S_TRUE, c, ok);
      default: begin
        if (is_dig(c)) r = st_push(r, K_NUM, flags, S_ICONT, c, ok);
        else r.ev = ev_none(ST_VALUE);
      end
    endcase
    return r;
  endfunction

  function automatic step_t int_end(step_t r, logic [7:0] c, logic top_nz);
    if (is_num_end(c)) r = st_pop(r, K_NUM, ST_AGAIN, 8'd0, top_nz);
    else if (c == ".") r = st_byte_to(r, S_FSTART, c);
    else if ((c == "e") || (c == "E")) r = st_byte_to(r, S_XSTART, c);
    else r.ev = ev_none(ST_DECIMAL);
    return r;
  endfunction

  function automatic step_t exp_start(step_t r, logic [7:0] c);
    if (is_dig(c)) r = st_byte_to(r, S_XICONT, c);
    else r.ev = ev_none(ST_DIGIT);
    return r;
  endfunction

  function automatic step_t eat_lit(step_t r, logic [1:0] which, logic [7:0] c,
                                    logic [3:0] cnt, logic top_nz);
    logic [3:0] n;
    logic [3:0] len;
    n = bump(cnt);
    len = (which == LIT_FALSE) ? 4'd5 : 4'd4;
    if (c != lit_char(which, cnt[2:0])) begin
      r.ev = ev_none(ST_LITERAL);
    end else begin
      r.cnt_wr = 1'b1;
      r.cnt = n;
      if (n == len) r = st_pop(r, K_LIT, ST_OK, c, top_nz);
      else r.ev = ev_byte(c);
    end
    return r;
  endfunction

  // One pass of the lexer over the frame state s.
  function automatic step_t lex_pass(lex_state_e s, logic [7:0] c, logic eoi,
                                     logic [31:0] val, logic [3:0] cnt,
                                     logic push_ok, logic top_nz, logic top_one);
    step_t r;
    logic [31:0] v;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cp;
    logic [3:0] n;
    r = '0;
    r.ev = ev_none(ST_OK);
    n = bump(cnt);
    v = '0;
    hi = '0;
    lo = '0;
    cp = '0;
    if (eoi) begin
      if (top_one && ((s == S_ICONT) || (s == S_IEND) || (s == S_FCONT) ||
                      (s == S_XICONT))) begin
        r = st_pop(r, K_NUM, ST_OK, 8'd0, top_nz);
      end else begin
        r.ev = ev_none((s != S_START) ? ST_NODATA : ST_FAIL);
      end
    end else if (is_ws(c) && (s <= S_MNEXT)) begin
      r.ev = ev_none(ST_OK);
    end else begin
      unique case (s)
        S_START:  r = take_value(r, 5'd0, c, push_ok);
        S_EFIRST: begin
          if (c == "]") r = st_pop(r, K_ARR, ST_OK, 8'd0, top_nz);
          else r = value_then(take_value(r, F_ELEM | F_FIRST, c, push_ok), S_ESEP);
        end
        S_ESEP: begin
          if (c == "]") r = st_pop(r, K_ARR, ST_OK, 8'd0, top_nz);
          else if (c == ",") r = st_to(r, S_ENEXT);
          else r.ev = ev_none(ST_COMMA);
        end
        S_ENEXT: r = value_then(take_value(r, F_ELEM, c, push_ok), S_ESEP);
        S_NFIRST: begin
          if (c == "}") r = st_pop(r, K_OBJ, ST_OK, 8'd0, top_nz);
          else if (c != "\"") r.ev = ev_none(ST_QUOTE);
          else r = value_then(st_push(r, K_STR, F_FIRST | F_NAME, S_STR, 8'd0, push_ok),
                              S_NSEP);
        end
        S_NSEP: begin
          if (c == ":") r = st_to(r, S_VSTART);
          else r.ev = ev_none(ST_COLON);
        end
        S_VSTART: r = value_then(take_value(r, F_VAL, c, push_ok), S_MSEP);
        S_MSEP: begin
          if (c == ",") r = st_to(r, S_MNEXT);
          else if (c == "}") r = st_pop(r, K_OBJ, ST_OK, 8'd0, top_nz);
          else r.ev = ev_none(ST_COMMA);
        end
        S_MNEXT: begin
          if (c != "\"") r.ev = ev_none(ST_QUOTE);
          else r = value_then(st_push(r, K_STR, F_NAME, S_STR, 8'd0, push_ok), S_NSEP);
        end
        S_STR: begin
          if (c == "\"") r = st_pop(r, K_STR, ST_OK, 8'd0, top_nz);
          else if (c == "\\") r = st_to(r, S_ESC);
          else if (c < 8'h20) r = st_pop(r, K_STR, ST_PRINT, 8'd0, top_nz);
          else r.ev = ev_byte(c);
        end
        S_ESC: begin
          case (c)
            "\"", "/", "\\": r = st_byte_to(r, S_STR, c);
            "b":     r = st_byte_to(r, S_STR, 8'd8);
            "f":     r = st_byte_to(r, S_STR, 8'd12);
            "n":     r = st_byte_to(r, S_STR, 8'd10);
            "r":     r = st_byte_to(r, S_STR, 8'd13);
            "t":     r = st_byte_to(r, S_STR, 8'd9);
            "u":     r = st_to(r, S_HEX);
            default: r.ev = ev_none(ST_ESC);
          endcase
        end
        S_HEX: begin
          if (!is_hex(c)) begin
            r.ev = ev_none(ST_HEX);
          end else begin
            v = ((cnt != 4'd0) ? (val << 4) : 32'd0) | {28'd0, nibble(c)};
            r.val_wr = 1'b1;
            r.val = v;
            r.cnt_wr = 1'b1;
            r.cnt = n;
            if (n < 4'd4) begin
              r.ev = ev_none(ST_OK);
            end else if ((v >= 32'hDC00) && (v <= 32'hDFFF)) begin
              r.ev = ev_none(ST_HI);
            end else if ((v >= 32'hD800) && (v <= 32'hDBFF)) begin
              r = st_to(r, S_LOW);
            end else begin
              r.ev = ev_code(v);
              r.cnt = 4'd0;
              r.wr = 1'b1;
              r.wr_state = S_STR;
            end
          end
        end
        S_LOW: begin
          if (((cnt == 4'd4) && (c == "\\")) || ((cnt == 4'd5) && (c == "u"))) begin
            r.cnt_wr = 1'b1;
            r.cnt = n;
            r.ev = ev_none(ST_OK);
          end else if (!is_hex(c)) begin
            r.ev = ev_none(ST_HEX);
          end else begin
            v = (val << 4) | {28'd0, nibble(c)};
            r.val_wr = 1'b1;
            r.val = v;
            r.cnt_wr = 1'b1;
            r.cnt = n;
            hi = {16'd0, v[31:16]};
            lo = {16'd0, v[15:0]};
            cp = ((hi - 32'hD800) << 10) + (lo - 32'hDC00) + 32'h10000;
            if (n < 4'd10) begin
              r.ev = ev_none(ST_OK);
            end else if ((lo < 32'hDC00) || (lo > 32'hDFFF)) begin
              r.ev = ev_none(ST_LO);
            end else begin
              r.ev = ev_code(cp);
              r.cnt = 4'd0;
              r.wr = 1'b1;
              r.wr_state = S_STR;
            end
          end
        end
        S_ISTART: begin
          if (c == "0") r = st_byte_to(r, S_IEND, c);
          else if (is_dig(c)) r = st_byte_to(r, S_ICONT, c);
          else r.ev = ev_none(ST_DIGIT);
        end
        S_ICONT: begin
          if (is_dig(c)) r.ev = ev_byte(c);
          else r = int_end(r, c, top_nz);
        end
        S_IEND: r = int_end(r, c, top_nz);
        S_FSTART: begin
          if (is_dig(c)) r = st_byte_to(r, S_FCONT, c);
          else r.ev = ev_none(ST_DIGIT);
        end
        S_FCONT: begin
          if (is_dig(c)) r.ev = ev_byte(c);
          else if ((c == "e") || (c == "E")) r = st_byte_to(r, S_XSTART, c);
          else r = st_pop(r, K_NUM, ST_AGAIN, 8'd0, top_nz);
        end
        S_XSTART: begin
          if ((c == "+") || (c == "-")) r = st_byte_to(r, S_XISTART, c);
          else r = exp_start(r, c);
        end
        S_XISTART: r = exp_start(r, c);
        S_XICONT: begin
          if (is_dig(c)) r.ev = ev_byte(c);
          else if (is_num_end(c)) r = st_pop(r, K_NUM, ST_AGAIN, 8'd0, top_nz);
          else r = st_pop(r, K_NUM, ST_DIGIT, 8'd0, top_nz);
        end
        S_FALSE: r = eat_lit(r, LIT_FALSE, c, cnt, top_nz);
        S_NULL:  r = eat_lit(r, LIT_NULL, c, cnt, top_nz);
        S_TRUE:  r = eat_lit(r, LIT_TRUE, c, cnt, top_nz);
        default: r.ev = ev_none(ST_FAIL);
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/jsl_ram.sv -----
`default_nettype none
module jsl_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/json_stream_lexer_top.sv -----
// A byte's event is registered and appears in the cycle after it is taken.
// Throughput: one byte per cycle when not stalled; a number that is closed
// by the next byte is finished and that byte lexed again in the same cycle.
// The top three frames live in registers; deeper frames sit in a RAM whose
// registered read ports prefetch the two frames below them every cycle.
// Reset: stack empty in the start state, escape state cleared, limit 64.
`default_nettype none
module json_stream_lexer_top
  import jsl_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      status_o,
  output logic [2:0]      event_type_o,
  output logic [2:0]      value_kind_o,
  output logic [4:0]      event_flags_o,
  output logic [2:0]      byte_count_o,
  output logic [7:0]      byte_zero_o,
  output logic [7:0]      byte_one_o,
  output logic [7:0]      byte_two_o,
  output logic [7:0]      byte_three_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  logic [AW-1:0] top_q, top_d;
  lex_state_e    cur_q, cur_d, n1_q, n1_d, n2_q, n2_d, n1_eff, n2_eff;
  frame_src_e    n1_src_q, n1_src_d, n2_src_q, n2_src_d;
  logic [31:0]   esc_val_q, esc_val_d;
  logic [3:0]    esc_cnt_q, esc_cnt_d;
  logic [6:0]    limit_q;
  logic          out_valid_q;
  event_t        ev_q, res;
  step_t         p1, p2;
  logic          again, in_acc;
  logic [CW-1:0] lim, top_ext;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, raddr_a, raddr_b;
  logic [4:0]    rdata_a, rdata_b;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Frames below the cached three are prefetched relative to the current top.
  assign raddr_a   = (top_q >= AW'(3)) ? top_q - AW'(1) - AW'(1) - AW'(1) : '0;
  assign raddr_b   = (top_q >= AW'(4)) ? raddr_a - AW'(1) : '0;
  assign ram_waddr = top_q - AW'(1) - AW'(1);

  jsl_ram #(
    .WIDTH(5),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (5'(n2_eff)),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    unique case (n1_src_q)
      SRC_RDA: n1_eff = lex_state_e'(rdata_a);
      SRC_RDB: n1_eff = lex_state_e'(rdata_b);
      default: n1_eff = n1_q;
    endcase
    unique case (n2_src_q)
      SRC_RDA: n2_eff = lex_state_e'(rdata_a);
      SRC_RDB: n2_eff = lex_state_e'(rdata_b);
      default: n2_eff = n2_q;
    endcase
  end

  always_comb begin
    top_ext = CW'(top_q);
    lim = (CW'(limit_q) > DepthC) ? DepthC : CW'(limit_q);
    p1 = lex_pass(cur_q, data_byte_i, end_of_input_i, esc_val_q, esc_cnt_q,
                  (top_ext + CW'(1)) < lim, top_q != '0, top_q == AW'(1));
    // The second pass runs in the enclosing frame, one level down.
    p2 = lex_pass(n1_eff, data_byte_i, 1'b0, esc_val_q, 4'd0,
                  top_ext < lim, top_ext > CW'(1), 1'b0);
    again = (p1.ev.status == ST_AGAIN);

    res = p1.ev;
    if (again) begin
      res.status = p2.ev.status;
      if (p2.ev.etype == EV_END) begin
        res.etype = EV_DEND;
        res.kind  = p2.ev.kind;
      end
    end

    esc_val_d = p1.val_wr ? p1.val : esc_val_q;
    esc_cnt_d = p1.cnt_wr ? p1.cnt : esc_cnt_q;
    if (again && p2.cnt_wr) begin
      esc_cnt_d = p2.cnt;
    end

    top_d    = top_q;
    cur_d    = cur_q;
    n1_d     = n1_eff;
    n2_d     = n2_eff;
    n1_src_d = SRC_REG;
    n2_src_d = SRC_REG;
    ram_we   = 1'b0;
    if (in_acc) begin
      if (again) begin
        if (p2.pop) begin
          top_d    = top_q - AW'(1) - AW'(1);
          cur_d    = n2_eff;
          n1_src_d = SRC_RDA;
          n2_src_d = SRC_RDB;
        end else if (p2.push) begin
          cur_d = p2.push_state;
          n1_d  = p2.wr ? p2.wr_state : n1_eff;
        end else begin
          top_d    = top_q - AW'(1);
          cur_d    = p2.wr ? p2.wr_state : n1_eff;
          n1_d     = n2_eff;
          n2_src_d = SRC_RDA;
        end
      end else if (p1.pop) begin
        top_d    = top_q - AW'(1);
        cur_d    = n1_eff;
        n1_d     = n2_eff;
        n2_src_d = SRC_RDA;
      end else if (p1.push) begin
        top_d  = top_q + AW'(1);
        cur_d  = p1.push_state;
        n1_d   = p1.wr ? p1.wr_state : cur_q;
        n2_d   = n1_eff;
        ram_we = (top_q >= AW'(2));
      end else if (p1.wr) begin
        cur_d = p1.wr_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      cur_q       <= S_START;
      n1_src_q    <= SRC_REG;
      n2_src_q    <= SRC_REG;
      esc_val_q   <= '0;
      esc_cnt_q   <= '0;
      limit_q     <= 7'd64;
      out_valid_q <= 1'b0;
    end else begin
      top_q    <= top_d;
      cur_q    <= cur_d;
      n1_src_q <= n1_src_d;
      n2_src_q <= n2_src_d;
      if (in_acc) begin
        esc_val_q <= esc_val_d;
        esc_cnt_q <= esc_cnt_d;
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d;
    n2_q <= n2_d;
    if (in_acc) begin
      ev_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = ev_q.status;
  assign event_type_o  = ev_q.etype;
  assign value_kind_o  = ev_q.kind;
  assign event_flags_o = ev_q.flags;
  assign byte_count_o  = ev_q.count;
  assign byte_zero_o   = ev_q.b0;
  assign byte_one_o    = ev_q.b1;
  assign byte_two_o    = ev_q.b2;
  assign byte_three_o  = ev_q.b3;

  // The bottom frame is never anything but the start state.
  a_bottom_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q == '0) |-> (cur_q == S_START))
    else $error("bottom frame left the start state");

  // The stack moves by at most one level up per word.
  a_top_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (CW'(top_q) <= CW'($past(top_q)) + CW'(1)))
    else $error("stack grew by more than one frame");

  // An overflow in the first pass leaves the stack as it was.
  a_over_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !again && (p1.ev.status == ST_OVER)) |=> $stable(top_q))
    else $error("overflow changed the stack");

  // A taken word always produces an event in the next cycle.
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("word taken without an event");

  // Content count and has-bytes flag agree.
  a_count_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((ev_q.count != 3'd0) == ev_q.flags[0]))
    else $error("byte count disagrees with has-bytes flag");

endmodule
`default_nettype wire
